>>> sv/bycg_pkg.sv
package bycg_pkg;

  // Field widths
  localparam int Q_W     = 32;   // control point / waypoint, Q16.16
  localparam int WGT_W   = 8;    // weight registers
  localparam int PNUM_W  = 10;   // point_number field
  localparam int RES_W   = 64;   // result_value field
  localparam int GW_W    = 48;   // gradient window entries, Q.16
  localparam int COST_W  = 63;   // cost accumulator (never negative)
  localparam int CFG_IDX_W = 1;

  // Datapath widths
  localparam int RMAG_W  = 35;   // |jerk residual|
  localparam int Z6_W    = 35;   // (|x|+3)/2, input of the divide by three
  localparam int EMAG_W  = 34;   // |waypoint error|
  localparam int WE_W    = 42;   // waypoint_weight * |error|
  localparam int DQ_W    = 42;   // round(we/3)

  // Shared multiply-accumulate unit: MAC_AW x MAC_DW per cycle, two digits
  localparam int MAC_AW  = 44;
  localparam int MAC_DW  = 22;
  localparam int ACC_W   = MAC_AW + 2 * MAC_DW;

  // Squares are scaled down by 2^16, rounded half up
  localparam int SQ_SHIFT = 16;
  localparam logic [ACC_W-1:0] SQ_RND = ACC_W'(1) << (SQ_SHIFT - 1);

  // floor(z/3) == (z * RECIP3) >> RECIP_SH for every z < 2^RECIP_SH
  localparam int RECIP_SH = 45;
  localparam logic [MAC_AW-1:0] RECIP3 = 44'hAAAAAAAAAAB;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_JERK_WEIGHT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYPOINT_WEIGHT = 1'b1;

  // Result kinds
  localparam logic KIND_GRAD = 1'b0;
  localparam logic KIND_COST = 1'b1;

  typedef struct packed {
    logic signed [Q_W-1:0] point_value;
    logic signed [Q_W-1:0] waypoint;
    logic                  last_point;
  } in_t;

  typedef struct packed {
    logic                    kind;
    logic [PNUM_W-1:0]       point_number;
    logic signed [RES_W-1:0] result_value;
    logic                    final_res;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_J_WT,
    ST_J_SQ,
    ST_J_ACC,
    ST_W_WT,
    ST_W_SQ,
    ST_W_ACC,
    ST_W_GRAD,
    ST_EMIT_G,
    ST_EMIT_C,
    ST_SHIFT
  } fsm_state_t;

  typedef enum logic [2:0] {
    OP_JW,     // jerk_weight * |r|
    OP_JSQ,    // (jw*|r|) * |r|
    OP_DIV6,   // z6 * RECIP3
    OP_WW,     // waypoint_weight * |e|
    OP_WSQ,    // (ww*|e|) * |e|
    OP_DIV3    // (ww*|e| + 1) * RECIP3
  } op_sel_t;

  typedef struct packed {
    logic start;
    logic rnd;
  } mac_req_t;

  typedef struct packed {
    logic in_valid;
    logic mac_busy;
    logic out_free;
    logic p_ge3;
    logic p_ge4;
    logic p_ge6;
    logic last;
  } fsm_stat_t;

  typedef struct packed {
    logic    idle;
    logic    accept;
    logic    prep;
    logic    mac_start;
    logic    mac_rnd;
    op_sel_t op_sel;
    logic    jgrad;
    logic    cost_add;
    logic    e_load;
    logic    we_load;
    logic    wgrad;
    logic    emit_grad;
    logic    emit_cost;
    logic    advance;
  } fsm_ctrl_t;

endpackage

>>> sv/bycg_mac.sv
module bycg_mac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bycg_pkg::mac_req_t           req,
  input  logic [bycg_pkg::MAC_AW-1:0]  op_a,
  input  logic [bycg_pkg::MAC_AW-1:0]  op_b,
  output logic                         busy,
  output logic [bycg_pkg::ACC_W-1:0]   prod
);
  import bycg_pkg::*;

  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic [MAC_AW-1:0]        a_r, a_nxt;
  logic [MAC_DW-1:0]        bhi_r, bhi_nxt;
  logic                     busy_r, busy_nxt;
  logic [MAC_AW-1:0]        mul_x;
  logic [MAC_DW-1:0]        mul_y;
  logic [MAC_AW+MAC_DW-1:0] pp;

  // one multiplier, low digit of b on start, high digit next cycle when nonzero
  always_comb begin
    mul_x = req.start ? op_a : a_r;
    mul_y = req.start ? op_b[MAC_DW-1:0] : bhi_r;
    pp    = mul_x * mul_y;
  end

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    bhi_nxt  = bhi_r;
    busy_nxt = busy_r;
    if (req.start) begin
      acc_nxt  = (req.rnd ? SQ_RND : '0) + ACC_W'(pp);
      a_nxt    = op_a;
      bhi_nxt  = op_b[MAC_AW-1:MAC_DW];
      busy_nxt = |op_b[MAC_AW-1:MAC_DW];
    end else if (busy_r) begin
      acc_nxt  = acc_r + {pp, {MAC_DW{1'b0}}};
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    bhi_r <= bhi_nxt;
  end

  assign busy = busy_r;
  assign prod = acc_r;

endmodule

>>> sv/bycg_fsm.sv
module bycg_fsm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bycg_pkg::fsm_stat_t  stat,
  output bycg_pkg::fsm_ctrl_t  ctrl
);
  import bycg_pkg::*;

  fsm_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (stat.in_valid) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = stat.p_ge3 ? ST_J_WT : ST_EMIT_G;
      ST_J_WT:   state_nxt = ST_J_SQ;
      ST_J_SQ:   if (!stat.mac_busy) state_nxt = ST_J_ACC;
      ST_J_ACC:  if (!stat.mac_busy) state_nxt = stat.p_ge4 ? ST_W_WT : ST_EMIT_G;
      ST_W_WT:   if (!stat.mac_busy) state_nxt = ST_W_SQ;
      ST_W_SQ:   if (!stat.mac_busy) state_nxt = ST_W_ACC;
      ST_W_ACC:  if (!stat.mac_busy) state_nxt = ST_W_GRAD;
      ST_W_GRAD: if (!stat.mac_busy) state_nxt = ST_EMIT_G;
      ST_EMIT_G: begin
        if (!stat.p_ge6 || stat.out_free) begin
          state_nxt = stat.last ? ST_EMIT_C : ST_SHIFT;
        end
      end
      ST_EMIT_C: if (stat.out_free) state_nxt = ST_IDLE;
      ST_SHIFT:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl        = '0;
    ctrl.op_sel = OP_JW;
    case (state_r)
      ST_IDLE: begin
        ctrl.idle   = 1'b1;
        ctrl.accept = stat.in_valid;
      end
      ST_PREP: ctrl.prep = 1'b1;
      ST_J_WT: begin
        ctrl.mac_start = 1'b1;
        ctrl.op_sel    = OP_JW;
      end
      ST_J_SQ: begin
        if (!stat.mac_busy) begin
          ctrl.jgrad     = 1'b1;
          ctrl.mac_start = 1'b1;
          ctrl.mac_rnd   = 1'b1;
          ctrl.op_sel    = OP_JSQ;
        end
      end
      ST_J_ACC: begin
        if (!stat.mac_busy) begin
          ctrl.cost_add  = 1'b1;
          ctrl.mac_start = stat.p_ge4;
          ctrl.op_sel    = OP_DIV6;
        end
      end
      ST_W_WT: begin
        if (!stat.mac_busy) begin
          ctrl.e_load    = 1'b1;
          ctrl.mac_start = 1'b1;
          ctrl.op_sel    = OP_WW;
        end
      end
      ST_W_SQ: begin
        if (!stat.mac_busy) begin
          ctrl.we_load   = 1'b1;
          ctrl.mac_start = 1'b1;
          ctrl.mac_rnd   = 1'b1;
          ctrl.op_sel    = OP_WSQ;
        end
      end
      ST_W_ACC: begin
        if (!stat.mac_busy) begin
          ctrl.cost_add  = 1'b1;
          ctrl.mac_start = 1'b1;
          ctrl.op_sel    = OP_DIV3;
        end
      end
      ST_W_GRAD: ctrl.wgrad = !stat.mac_busy;
      ST_EMIT_G: ctrl.emit_grad = stat.p_ge6 && stat.out_free;
      ST_EMIT_C: ctrl.emit_cost = stat.out_free;
      ST_SHIFT:  ctrl.advance = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/bspline_yaw_cost_gradient.sv
// Channel | Ports                          | Direction | Transfer when
// input   | in_valid, in_stall, in_data    | in        | in_valid && !in_stall
// result  | out_valid, out_stall, out_data | out       | out_valid && !out_stall
// config  | cfg_we, cfg_index, cfg_wdata   | in        | cfg_we
//
// Flow: one control point at a time; the work per point is set by the chain of up to six
// products (jerk weight, jerk square, divide by six, waypoint weight, waypoint
// square, divide by three) through the one 44x22 multiply-accumulate unit; the
// divides always take two passes, each square takes a second pass when its
// multiplier has upper bits set. The first three points need no products, the
// fourth only the two jerk products. Loading a gradient or cost item also waits
// while out_stall holds the output register.
// Reset: synchronous, active low; weights go to 1 and 10, all window state to 0.
// A result item waits in the output register while the next point is taken.
module bspline_yaw_cost_gradient #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  bycg_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output bycg_pkg::out_t                       out_data,
  input  logic                                 cfg_we,
  input  logic [bycg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bycg_pkg::WGT_W-1:0]           cfg_wdata
);
  import bycg_pkg::*;

  localparam int PW = $clog2(MAX_POINTS);

  // configuration
  logic [WGT_W-1:0] jw_r, jw_nxt;
  logic [WGT_W-1:0] ww_r, ww_nxt;

  // sequence state
  logic signed [Q_W-1:0]  rp_r [3];
  logic signed [Q_W-1:0]  rp_nxt [3];
  logic signed [GW_W-1:0] gw_r [4];
  logic signed [GW_W-1:0] gw_nxt [4];
  logic [COST_W-1:0]      cost_r, cost_nxt;
  logic [PW-1:0]          ps_r, ps_nxt;

  // current point and intermediates
  logic signed [Q_W-1:0] q_r, q_nxt;
  logic signed [Q_W-1:0] wp_r, wp_nxt;
  logic                  last_r, last_nxt;
  logic [RMAG_W-1:0]     r_mag_r, r_mag_nxt;
  logic                  r_neg_r, r_neg_nxt;
  logic [Z6_W-1:0]       z6_r, z6_nxt;
  logic                  x_neg_r, x_neg_nxt;
  logic [EMAG_W-1:0]     e_mag_r, e_mag_nxt;
  logic [WE_W-1:0]       we_r, we_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic out_free;

  // sequencer and shared unit
  fsm_stat_t        stat;
  fsm_ctrl_t        ctrl;
  mac_req_t         mac_req;
  logic [MAC_AW-1:0] mac_a, mac_b;
  logic             mac_busy;
  logic [ACC_W-1:0] mac_prod;

  // combinational datapath
  logic signed [35:0] q0x, q1x, q2x, qx, r_s;
  logic signed [36:0] p0x, p1x, p2x, wpx, x_s;
  logic [35:0]        r_abs;
  logic [36:0]        x_abs;
  logic [35:0]        z6_sum;
  logic [GW_W-1:0]    g_mag, g_s, g3_s;
  logic [GW_W-1:0]    d_mag, d4_mag, d_s, d4_s;
  logic [COST_W-1:0]  term;
  logic [COST_W:0]    cost_sum;
  logic [PW+PNUM_W-1:0] pn_ext;

  assign out_free = !out_valid_r || !out_stall;

  assign stat.in_valid = in_valid;
  assign stat.mac_busy = mac_busy;
  assign stat.out_free = out_free;
  assign stat.p_ge3    = ps_r >= PW'(3);
  assign stat.p_ge4    = ps_r >= PW'(4);
  assign stat.p_ge6    = ps_r >= PW'(6);
  assign stat.last     = last_r;

  bycg_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  assign mac_req.start = ctrl.mac_start;
  assign mac_req.rnd   = ctrl.mac_rnd;

  // operand select for the shared unit
  always_comb begin
    mac_a = MAC_AW'(r_mag_r);
    mac_b = MAC_AW'(jw_r);
    case (ctrl.op_sel)
      OP_JW: begin
        mac_a = MAC_AW'(r_mag_r);
        mac_b = MAC_AW'(jw_r);
      end
      OP_JSQ: begin
        mac_a = mac_prod[MAC_AW-1:0];
        mac_b = MAC_AW'(r_mag_r);
      end
      OP_DIV6: begin
        mac_a = MAC_AW'(z6_r);
        mac_b = RECIP3;
      end
      OP_WW: begin
        mac_a = MAC_AW'(mac_prod[RECIP_SH +: EMAG_W]);
        mac_b = MAC_AW'(ww_r);
      end
      OP_WSQ: begin
        mac_a = mac_prod[MAC_AW-1:0];
        mac_b = MAC_AW'(e_mag_r);
      end
      OP_DIV3: begin
        mac_a = MAC_AW'(we_r) + MAC_AW'(1);
        mac_b = RECIP3;
      end
      default: ;
    endcase
  end

  bycg_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .busy  (mac_busy),
    .prod  (mac_prod)
  );

  // residuals: r = -q0 + 3q1 - 3q2 + q, x = q0 + 4q1 + q2 - 6wp
  always_comb begin
    q0x = 36'(rp_r[0]);
    q1x = 36'(rp_r[1]);
    q2x = 36'(rp_r[2]);
    qx  = 36'(q_r);
    r_s = qx - q0x + (q1x <<< 1) + q1x - (q2x <<< 1) - q2x;
    r_abs = r_s[35] ? 36'(-r_s) : 36'(r_s);

    p0x = 37'(rp_r[0]);
    p1x = 37'(rp_r[1]);
    p2x = 37'(rp_r[2]);
    wpx = 37'(wp_r);
    x_s = p0x + (p1x <<< 2) + p2x - (wpx <<< 2) - (wpx <<< 1);
    x_abs = x_s[36] ? 37'(-x_s) : 37'(x_s);
    // round half away: floor((|x|+3)/6) = floor(((|x|+3)>>1)/3)
    z6_sum = 36'(x_abs[RMAG_W-1:0]) + 36'd3;
  end

  // gradient terms
  always_comb begin
    g_mag  = GW_W'({mac_prod[WE_W-1:0], 1'b0});
    g_s    = r_neg_r ? -g_mag : g_mag;
    g3_s   = g_s + (g_s << 1);
    d_mag  = GW_W'(mac_prod[RECIP_SH +: DQ_W]);
    d4_mag = GW_W'(we_r) + d_mag;       // round(4we/3) = we + round(we/3)
    d_s    = x_neg_r ? -d_mag : d_mag;
    d4_s   = x_neg_r ? -d4_mag : d4_mag;
    term     = mac_prod[SQ_SHIFT +: COST_W];
    cost_sum = {1'b0, cost_r} + {1'b0, term};
    pn_ext   = (PW + PNUM_W)'(ps_r - PW'(3));
  end

  always_comb begin
    jw_nxt = jw_r;
    ww_nxt = ww_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_JERK_WEIGHT:     jw_nxt = cfg_wdata;
        CFG_WAYPOINT_WEIGHT: ww_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    rp_nxt    = rp_r;
    gw_nxt    = gw_r;
    cost_nxt  = cost_r;
    ps_nxt    = ps_r;
    q_nxt     = q_r;
    wp_nxt    = wp_r;
    last_nxt  = last_r;
    r_mag_nxt = r_mag_r;
    r_neg_nxt = r_neg_r;
    z6_nxt    = z6_r;
    x_neg_nxt = x_neg_r;
    e_mag_nxt = e_mag_r;
    we_nxt    = we_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (ctrl.accept) begin
      q_nxt    = in_data.point_value;
      wp_nxt   = in_data.waypoint;
      last_nxt = in_data.last_point;
    end
    if (ctrl.prep) begin
      r_mag_nxt = r_abs[RMAG_W-1:0];
      r_neg_nxt = r_s[35];
      z6_nxt    = z6_sum[Z6_W:1];
      x_neg_nxt = x_s[36];
    end
    if (ctrl.jgrad) begin
      gw_nxt[0] = gw_r[0] - g_s;
      gw_nxt[1] = gw_r[1] + g3_s;
      gw_nxt[2] = gw_r[2] - g3_s;
      gw_nxt[3] = g_s;
    end
    if (ctrl.cost_add) begin
      cost_nxt = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
    end
    if (ctrl.e_load) begin
      e_mag_nxt = mac_prod[RECIP_SH +: EMAG_W];
    end
    if (ctrl.we_load) begin
      we_nxt = mac_prod[WE_W-1:0];
    end
    if (ctrl.wgrad) begin
      gw_nxt[0] = gw_r[0] + d_s;
      gw_nxt[1] = gw_r[1] + d4_s;
      gw_nxt[2] = gw_r[2] + d_s;
    end
    if (ctrl.emit_grad) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.kind         = KIND_GRAD;
      out_data_nxt.point_number = pn_ext[PNUM_W-1:0];
      out_data_nxt.result_value = RES_W'(gw_r[0]);
      out_data_nxt.final_res    = 1'b0;
    end
    if (ctrl.emit_cost) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.kind         = KIND_COST;
      out_data_nxt.point_number = '0;
      out_data_nxt.result_value = RES_W'(cost_r);
      out_data_nxt.final_res    = 1'b1;
      // sequence done: back to reset values
      rp_nxt   = '{default: '0};
      gw_nxt   = '{default: '0};
      cost_nxt = '0;
      ps_nxt   = '0;
    end
    if (ctrl.advance) begin
      gw_nxt[0] = gw_r[1];
      gw_nxt[1] = gw_r[2];
      gw_nxt[2] = gw_r[3];
      gw_nxt[3] = '0;
      rp_nxt[0] = rp_r[1];
      rp_nxt[1] = rp_r[2];
      rp_nxt[2] = q_r;
      if (ps_r < PW'(MAX_POINTS - 1)) begin
        ps_nxt = ps_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jw_r        <= WGT_W'(1);
      ww_r        <= WGT_W'(10);
      rp_r        <= '{default: '0};
      gw_r        <= '{default: '0};
      cost_r      <= '0;
      ps_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      jw_r        <= jw_nxt;
      ww_r        <= ww_nxt;
      rp_r        <= rp_nxt;
      gw_r        <= gw_nxt;
      cost_r      <= cost_nxt;
      ps_r        <= ps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    wp_r       <= wp_nxt;
    last_r     <= last_nxt;
    r_mag_r    <= r_mag_nxt;
    r_neg_r    <= r_neg_nxt;
    z6_r       <= z6_nxt;
    x_neg_r    <= x_neg_nxt;
    e_mag_r    <= e_mag_nxt;
    we_r       <= we_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = !ctrl.idle;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // a taken point keeps the input closed for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after a transfer");

  // the shared unit never gets a new product while one is in flight
  a_mac_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.mac_start |-> !mac_busy)
    else $error("multiply issued while unit busy");

  // the newest window slot is empty whenever a point can be taken
  a_window_tail_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (gw_r[3] == '0))
    else $error("gradient window tail not clear at idle");

  // loading the final cost item clears the sequence state
  a_clear_on_cost: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit_cost |=> (ps_r == '0 && cost_r == '0 && out_data.final_res))
    else $error("sequence not cleared after cost item");
`endif

endmodule

>>> tb/bspline_yaw_cost_gradient_tb.sv
module bspline_yaw_cost_gradient_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bycg_pkg::*;

  localparam int SEQ_CAP = 1024;          // MAX_POINTS of the instance
  localparam int IDLE_PCT = 9;            // idle / stall rate per side
  localparam int SETTLE_CYCLES = 40;      // a couple of points' worth of work
  localparam int STUCK_LIMIT = 3000;      // cycles with no transfer at all
  localparam int PHASE_POINTS = 32;       // random points per weight setting
  localparam int OVERLONG_LEN = 1030;     // past the point index cap
  localparam longint unsigned COST_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum int {
    YAW_FULL,       // any 32-bit value
    YAW_NEAR_ZERO,  // within +-1.0, hits rounding ties often
    YAW_EXTREME,    // min, max, 0, -1
    YAW_WALK        // smooth random walk, waypoint close to the path
  } yaw_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_JERK_WEIGHT;
  logic [WGT_W-1:0] cfg_wdata = '0;

  bspline_yaw_cost_gradient #(.MAX_POINTS(SEQ_CAP)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mirror of the block: weights, point window, gradient window, cost.
  int jerk_w = 1;
  int way_w = 10;
  longint prev_pts[3];
  longint grad_win[4];
  longint unsigned cost_acc;
  int unsigned next_idx;

  out_t pending_results[$];

  // Run bookkeeping
  bit calm = 1'b0;         // no idling on either side while set
  int walk_pos = 0;
  int points_sent = 0;
  int seqs_sent = 0;
  int grads_seen = 0;
  int costs_seen = 0;
  int fail_count = 0;

  function automatic longint unsigned abs_val(input longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  // x / d to nearest, ties away from zero
  function automatic longint div_nearest(input longint x, input longint unsigned d);
    longint unsigned quo;
    quo = (abs_val(x) * 2 + d) / (2 * d);
    return (x < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  // w * m^2 / 2^16, rounded half up; split so nothing leaves 64 bits
  function automatic longint unsigned scaled_square(input longint unsigned m,
                                                    input longint unsigned w);
    longint unsigned hi, lo, low_part;
    hi = m >> 16;
    lo = m & 64'hFFFF;
    low_part = (w * lo * lo + 64'h8000) >> 16;
    return ((w * hi * hi) << 16) + 2 * w * hi * lo + low_part;
  endfunction

  function automatic void add_to_cost(input longint unsigned t);
    if (t > COST_TOP - cost_acc) cost_acc = COST_TOP;
    else cost_acc += t;
  endfunction

  function automatic void clear_window();
    foreach (prev_pts[k]) prev_pts[k] = 0;
    foreach (grad_win[k]) grad_win[k] = 0;
    cost_acc = 0;
    next_idx = 0;
  endfunction

  // Fold one accepted control point into the mirror, queue what it yields.
  function automatic void take_point(input in_t item);
    longint q, wp, q0, q1, q2, r, g, e, we;
    int unsigned p;
    out_t res;
    q = item.point_value;
    wp = item.waypoint;
    p = next_idx;
    grad_win[3] = 0;
    if (p >= 3) begin
      q0 = prev_pts[0];
      q1 = prev_pts[1];
      q2 = prev_pts[2];
      r = -q0 + 3 * q1 - 3 * q2 + q;
      g = 2 * longint'(jerk_w) * r;
      add_to_cost(scaled_square(abs_val(r), longint'(jerk_w)));
      grad_win[0] -= g;
      grad_win[1] += 3 * g;
      grad_win[2] -= 3 * g;
      grad_win[3] += g;
      if (p >= 4) begin
        e = div_nearest(q0 + 4 * q1 + q2 - 6 * wp, 6);
        we = longint'(way_w) * e;
        add_to_cost(scaled_square(abs_val(e), longint'(way_w)));
        grad_win[0] += div_nearest(we, 3);
        grad_win[1] += div_nearest(4 * we, 3);
        grad_win[2] += div_nearest(we, 3);
      end
    end
    if (p >= 6) begin
      res.kind = KIND_GRAD;
      res.point_number = PNUM_W'(p - 3);
      res.result_value = grad_win[0];
      res.final_res = 1'b0;
      pending_results = {pending_results, res};
    end
    if (item.last_point) begin
      res.kind = KIND_COST;
      res.point_number = '0;
      res.result_value = cost_acc;
      res.final_res = 1'b1;
      pending_results = {pending_results, res};
      clear_window();
    end else begin
      grad_win[0] = grad_win[1];
      grad_win[1] = grad_win[2];
      grad_win[2] = grad_win[3];
      grad_win[3] = 0;
      prev_pts[0] = prev_pts[1];
      prev_pts[1] = prev_pts[2];
      prev_pts[2] = q;
      if (next_idx < SEQ_CAP - 1) next_idx++;
    end
  endfunction

  function automatic logic signed [Q_W-1:0] rand_yaw(input yaw_style_t style);
    case (style)
      YAW_NEAR_ZERO: return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
      YAW_EXTREME: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return '0;
          default: return -32'sd1;
        endcase
      end
      YAW_WALK: return walk_pos + int'($urandom_range(0, 32'h2000)) - 32'sh1000;
      default: return $urandom;
    endcase
  endfunction

  // One input transfer; random idle cycles ahead of it unless calm.
  task automatic send_point(input in_t item);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_point(item);
    points_sent++;
  endtask

  task automatic send_sequence(input int len, input yaw_style_t style);
    in_t item;
    for (int k = 0; k < len; k++) begin
      if (style == YAW_WALK) walk_pos += int'($urandom_range(0, 32'h6_0000)) - 32'sh3_0000;
      item.point_value = (style == YAW_WALK) ? walk_pos : rand_yaw(style);
      item.waypoint = rand_yaw(style);
      item.last_point = (k == len - 1);
      send_point(item);
    end
    seqs_sent++;
  endtask

  // Wait out everything in flight, including a point that yields nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_weights(input int jw, input int ww);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_JERK_WEIGHT;
    cfg_wdata <= WGT_W'(jw);
    @(posedge clk);
    jerk_w = jw;
    cfg_index <= CFG_WAYPOINT_WEIGHT;
    cfg_wdata <= WGT_W'(ww);
    @(posedge clk);
    way_w = ww;
    cfg_we <= 1'b0;
  endtask

  // Reset weights; short sequences: the cost stays zero below N=4, no gradient below
  // N=7, and at N=7 the lone gradient comes out just ahead of the cost.
  task automatic test_short_sequences();
    send_sequence(1, YAW_NEAR_ZERO);
    send_sequence(3, YAW_NEAR_ZERO);
    send_sequence(4, YAW_EXTREME);
    send_sequence(7, YAW_FULL);
  endtask

  // Full-swing zigzag at top weights pins the cost at its ceiling.
  task automatic test_cost_saturation();
    in_t item;
    set_weights(255, 255);
    for (int k = 0; k < 12; k++) begin
      item.point_value = k[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      item.waypoint = k[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      item.last_point = (k == 11);
      send_point(item);
    end
    seqs_sent++;
  endtask

  // Random sequences under a sweep of weight pairs, extremes included.
  task automatic test_weight_sweep();
    int jw, ww, start;
    yaw_style_t style;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin jw = 0; ww = 0; end
        1: begin jw = 255; ww = 255; end
        2: begin jw = 0; ww = 255; end
        3: begin jw = 255; ww = 0; end
        4: begin jw = 1; ww = 10; end
        default: begin jw = $urandom_range(255); ww = $urandom_range(255); end
      endcase
      set_weights(jw, ww);
      calm = (phase == 2 || phase == 3);
      start = points_sent;
      while (points_sent - start < PHASE_POINTS) begin
        case ($urandom_range(9))
          0, 1: style = YAW_FULL;
          2: style = YAW_EXTREME;
          3, 4: style = YAW_NEAR_ZERO;
          default: style = YAW_WALK;
        endcase
        if ($urandom_range(5) == 0) send_sequence($urandom_range(13, 40), style);
        else send_sequence($urandom_range(1, 12), style);
      end
    end
    calm = 1'b0;
  endtask

  // Past the index cap the point number sticks; state must clear after.
  task automatic test_overlong_sequence();
    set_weights($urandom_range(255), $urandom_range(255));
    send_sequence(OVERLONG_LEN, YAW_WALK);
    send_sequence(8, YAW_FULL);
  endtask

  // Result side: random stall, checked transfer by transfer.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d point %0d value %0d",
               out_data.kind, out_data.point_number, out_data.result_value);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.kind == KIND_COST) costs_seen++;
        else grads_seen++;
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          fail_count++;
        end
        if (out_data.point_number !== want.point_number) begin
          $error("point_number: expected %0d, got %0d",
                 want.point_number, out_data.point_number);
          fail_count++;
        end
        if (out_data.result_value !== want.result_value) begin
          $error("result_value: expected %0d, got %0d",
                 want.result_value, out_data.result_value);
          fail_count++;
        end
        if (out_data.final_res !== want.final_res) begin
          $error("final_res: expected %0d, got %0d", want.final_res, out_data.final_res);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results pending",
               STUCK_LIMIT, pending_results.size());
      $display("** bspline_yaw_cost_gradient: FAILED **");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    clear_window();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_sequences();
    test_cost_saturation();
    test_weight_sweep();
    test_overlong_sequence();
    settle();

    $display("%0d control points in %0d sequences, weights swept 0..255",
             points_sent, seqs_sent);
    $display("%0d gradient and %0d cost transfers checked, %0d mismatches",
             grads_seen, costs_seen, fail_count);
    if (fail_count == 0) begin
      $display("** bspline_yaw_cost_gradient: PASSED **");
    end else begin
      $display("** bspline_yaw_cost_gradient: FAILED **");
    end
    $finish;
  end

endmodule
